// ===== hw/rtl/cube_map_face_select_uv_unit_assert.svh =====
// assertion macros for the cube map face select rtl
`ifndef CUBE_MAP_FACE_SELECT_UV_UNIT_ASSERT_SVH
`define CUBE_MAP_FACE_SELECT_UV_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CMFS_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CMFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cmfs_pkg.sv =====
// shared types and constants for the cube map face select unit
package cmfs_pkg;

  localparam int DIR_W          = 16;  // signed direction component
  localparam int MAG_W          = 16;  // magnitude, up to 2^15
  localparam int NUM_W          = 17;  // sc + ma, up to 2^16
  localparam int FACE_W         = 3;
  localparam int COORD_W        = 16;  // output coordinate port width
  localparam int COORD_BITS_DEF = 16;

  localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

  // side info that rides along the divider stages
  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic              degen;
  } side_t;

endpackage

// ===== hw/rtl/cmfs_div_stage.sv =====
// one registered restoring-division step for the u and v lanes
module cmfs_div_stage import cmfs_pkg::*; #(
  parameter int QW = COORD_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             en,
  input  side_t            side_i,
  input  logic [MAG_W-1:0] m_i,
  input  logic [MAG_W-1:0] r_u_i,
  input  logic [QW-1:0]    q_u_i,
  input  logic [MAG_W-1:0] r_v_i,
  input  logic [QW-1:0]    q_v_i,
  output side_t            side_o,
  output logic [MAG_W-1:0] m_o,
  output logic [MAG_W-1:0] r_u_o,
  output logic [QW-1:0]    q_u_o,
  output logic [MAG_W-1:0] r_v_o,
  output logic [QW-1:0]    q_v_o
);

  side_t            side_r;
  logic [MAG_W-1:0] m_r, r_u_r, r_v_r, r_u_nxt, r_v_nxt;
  logic [QW-1:0]    q_u_r, q_v_r, q_u_nxt, q_v_nxt;
  logic [MAG_W:0]   r2_u, r2_v, d_u, d_v;
  logic             bit_u, bit_v;

  always_comb begin
    r2_u  = {r_u_i, 1'b0};
    r2_v  = {r_v_i, 1'b0};
    d_u   = r2_u - {1'b0, m_i};
    d_v   = r2_v - {1'b0, m_i};
    bit_u = (r2_u >= {1'b0, m_i});
    bit_v = (r2_v >= {1'b0, m_i});
    r_u_nxt = bit_u ? d_u[MAG_W-1:0] : r2_u[MAG_W-1:0];
    r_v_nxt = bit_v ? d_v[MAG_W-1:0] : r2_v[MAG_W-1:0];
    q_u_nxt = {q_u_i[QW-2:0], bit_u};
    q_v_nxt = {q_v_i[QW-2:0], bit_v};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      m_r    <= m_i;
      r_u_r  <= r_u_nxt;
      r_v_r  <= r_v_nxt;
      q_u_r  <= q_u_nxt;
      q_v_r  <= q_v_nxt;
    end
  end

  assign side_o = side_r;
  assign m_o    = m_r;
  assign r_u_o  = r_u_r;
  assign q_u_o  = q_u_r;
  assign r_v_o  = r_v_r;
  assign q_v_o  = q_v_r;

endmodule

// ===== hw/rtl/cube_map_face_select_uv_unit.sv =====
// top level of the cube map face select unit with fixed-point face coordinates
//
//   channel | ports                                     | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_ready, in_dir_x/y/z          | to unit
//   out     | out_valid, out_ready, out_face,           | from unit
//           | out_coord_u, out_coord_v, out_degenerate  |
//
// one item per cycle sustained while the skid slot is free; the stages come from
// the bit-per-stage divider: one stage for the integer part, COORD_BITS - 1
// stages for fraction bits, plus abs, select, add and output register stages
// rst_n is synchronous; it clears the valid bits of every stage and the skid slot
// the whole pipeline moves on one enable; a one-item skid slot behind the output
// register catches the item in flight when out_ready drops, so nothing is lost
`include "cube_map_face_select_uv_unit_assert.svh"

module cube_map_face_select_uv_unit import cmfs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DIR_W-1:0]  in_dir_x,
  input  logic signed [DIR_W-1:0]  in_dir_y,
  input  logic signed [DIR_W-1:0]  in_dir_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [FACE_W-1:0]        out_face,
  output logic [COORD_W-1:0]       out_coord_u,
  output logic [COORD_W-1:0]       out_coord_v,
  output logic                     out_degenerate
);

  // quotient is COORD_BITS + 1 wide: integer part 0..2 plus fraction bits
  localparam int QW    = COORD_BITS + 1;
  localparam int NSTEP = COORD_BITS - 1;
  localparam int NV    = 4 + NSTEP;      // stages before the output register
  localparam int EXT_W = COORD_BITS + COORD_W;

  typedef struct packed {
    logic [FACE_W-1:0]  face;
    logic [COORD_W-1:0] cu;
    logic [COORD_W-1:0] cv;
    logic               degen;
  } res_t;

  // output and skid valid bits; the skid bit is needed by the global advance
  logic o_valid_r, o_valid_nxt, sk_valid_r, sk_valid_nxt;

  // global advance: the pipeline moves whenever the skid slot is free
  logic          en;
  logic [NV-1:0] v_r, v_nxt;

  assign en       = !sk_valid_r;
  assign in_ready = en;
  assign v_nxt    = {v_r[NV-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  // stage 1: magnitudes; the negation is one bit wider so -32768 does not wrap
  logic signed [DIR_W-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [MAG_W-1:0]        s1_ax_r, s1_ay_r, s1_az_r;
  logic [MAG_W-1:0]        ax_nxt, ay_nxt, az_nxt;
  logic signed [DIR_W:0]   xe, ye, ze, xn, yn, zn;

  always_comb begin
    xe = {in_dir_x[DIR_W-1], in_dir_x};
    ye = {in_dir_y[DIR_W-1], in_dir_y};
    ze = {in_dir_z[DIR_W-1], in_dir_z};
    xn = -xe;
    yn = -ye;
    zn = -ze;
    ax_nxt = in_dir_x[DIR_W-1] ? xn[MAG_W-1:0] : xe[MAG_W-1:0];
    ay_nxt = in_dir_y[DIR_W-1] ? yn[MAG_W-1:0] : ye[MAG_W-1:0];
    az_nxt = in_dir_z[DIR_W-1] ? zn[MAG_W-1:0] : ze[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r  <= in_dir_x;
      s1_y_r  <= in_dir_y;
      s1_z_r  <= in_dir_z;
      s1_ax_r <= ax_nxt;
      s1_ay_r <= ay_nxt;
      s1_az_r <= az_nxt;
    end
  end

  // stage 2: major axis by strict compare; a tie goes to the later axis, z over y over x
  logic signed [DIR_W:0] s2_sc_r, s2_tc_r, sc_nxt, tc_nxt;
  logic signed [DIR_W:0] x1, y1, z1;
  logic [MAG_W-1:0]      s2_ma_r, ma_nxt;
  side_t                 s2_side_r, side2_nxt;
  logic                  x_maj, y_maj, x_pos, y_pos, z_pos;

  always_comb begin
    x1    = {s1_x_r[DIR_W-1], s1_x_r};
    y1    = {s1_y_r[DIR_W-1], s1_y_r};
    z1    = {s1_z_r[DIR_W-1], s1_z_r};
    x_maj = (s1_ax_r > s1_ay_r) && (s1_ax_r > s1_az_r);
    y_maj = !x_maj && (s1_ay_r > s1_az_r);
    // positive means strictly above zero
    x_pos = !s1_x_r[DIR_W-1] && (s1_x_r != '0);
    y_pos = !s1_y_r[DIR_W-1] && (s1_y_r != '0);
    z_pos = !s1_z_r[DIR_W-1] && (s1_z_r != '0);
    side2_nxt.degen = (s1_ax_r == '0) && (s1_ay_r == '0) && (s1_az_r == '0);
    if (x_maj) begin
      ma_nxt = s1_ax_r;
      tc_nxt = y1;
      if (x_pos) begin
        side2_nxt.face = FACE_PX;
        sc_nxt         = z1;
      end else begin
        side2_nxt.face = FACE_NX;
        sc_nxt         = -z1;
      end
    end else if (y_maj) begin
      ma_nxt = s1_ay_r;
      sc_nxt = x1;
      if (y_pos) begin
        side2_nxt.face = FACE_PY;
        tc_nxt         = z1;
      end else begin
        side2_nxt.face = FACE_NY;
        tc_nxt         = -z1;
      end
    end else begin
      ma_nxt = s1_az_r;
      tc_nxt = y1;
      if (z_pos) begin
        side2_nxt.face = FACE_PZ;
        sc_nxt         = -x1;
      end else begin
        side2_nxt.face = FACE_NZ;
        sc_nxt         = x1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sc_r   <= sc_nxt;
      s2_tc_r   <= tc_nxt;
      s2_ma_r   <= ma_nxt;
      s2_side_r <= side2_nxt;
    end
  end

  // stage 3: shift into [0, 2*ma]
  logic [NUM_W-1:0] s3_nu_r, s3_nv_r;
  logic [MAG_W-1:0] s3_ma_r;
  side_t            s3_side_r;
  logic [NUM_W:0]   su, sv;

  always_comb begin
    su = {s2_sc_r[DIR_W], s2_sc_r} + {2'b00, s2_ma_r};
    sv = {s2_tc_r[DIR_W], s2_tc_r} + {2'b00, s2_ma_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_nu_r   <= su[NUM_W-1:0];
      s3_nv_r   <= sv[NUM_W-1:0];
      s3_ma_r   <= s2_ma_r;
      s3_side_r <= s2_side_r;
    end
  end

  // stage 4: integer part of num / ma is 0, 1 or 2; remainder stays below ma
  logic [MAG_W-1:0] s4_ru_r, s4_rv_r, ru_nxt, rv_nxt;
  logic [1:0]       s4_iu_r, s4_iv_r, iu_nxt, iv_nxt;
  logic [MAG_W-1:0] s4_ma_r;
  side_t            s4_side_r;
  logic [NUM_W-1:0] m1, m2, u_m1, u_m2, v_m1, v_m2;

  always_comb begin
    m1   = {1'b0, s3_ma_r};
    m2   = {s3_ma_r, 1'b0};
    u_m1 = s3_nu_r - m1;
    u_m2 = s3_nu_r - m2;
    v_m1 = s3_nv_r - m1;
    v_m2 = s3_nv_r - m2;
    if (s3_nu_r >= m2) begin
      iu_nxt = 2'd2;
      ru_nxt = u_m2[MAG_W-1:0];
    end else if (s3_nu_r >= m1) begin
      iu_nxt = 2'd1;
      ru_nxt = u_m1[MAG_W-1:0];
    end else begin
      iu_nxt = 2'd0;
      ru_nxt = s3_nu_r[MAG_W-1:0];
    end
    if (s3_nv_r >= m2) begin
      iv_nxt = 2'd2;
      rv_nxt = v_m2[MAG_W-1:0];
    end else if (s3_nv_r >= m1) begin
      iv_nxt = 2'd1;
      rv_nxt = v_m1[MAG_W-1:0];
    end else begin
      iv_nxt = 2'd0;
      rv_nxt = s3_nv_r[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ru_r   <= ru_nxt;
      s4_rv_r   <= rv_nxt;
      s4_iu_r   <= iu_nxt;
      s4_iv_r   <= iv_nxt;
      s4_ma_r   <= s3_ma_r;
      s4_side_r <= s3_side_r;
    end
  end

  // fraction stages: one quotient bit per lane per stage
  side_t            ch_side [0:NSTEP];
  logic [MAG_W-1:0] ch_m    [0:NSTEP];
  logic [MAG_W-1:0] ch_ru   [0:NSTEP];
  logic [MAG_W-1:0] ch_rv   [0:NSTEP];
  logic [QW-1:0]    ch_qu   [0:NSTEP];
  logic [QW-1:0]    ch_qv   [0:NSTEP];

  assign ch_side[0] = s4_side_r;
  assign ch_m[0]    = s4_ma_r;
  assign ch_ru[0]   = s4_ru_r;
  assign ch_rv[0]   = s4_rv_r;
  assign ch_qu[0]   = QW'(s4_iu_r);
  assign ch_qv[0]   = QW'(s4_iv_r);

  for (genvar k = 0; k < NSTEP; k++) begin : g_div
    cmfs_div_stage #(
      .QW (QW)
    ) u_step (
      .clk    (clk),
      .en     (en),
      .side_i (ch_side[k]),
      .m_i    (ch_m[k]),
      .r_u_i  (ch_ru[k]),
      .q_u_i  (ch_qu[k]),
      .r_v_i  (ch_rv[k]),
      .q_v_i  (ch_qv[k]),
      .side_o (ch_side[k+1]),
      .m_o    (ch_m[k+1]),
      .r_u_o  (ch_ru[k+1]),
      .q_u_o  (ch_qu[k+1]),
      .r_v_o  (ch_rv[k+1]),
      .q_v_o  (ch_qv[k+1])
    );
  end

  // saturate: only num == 2*ma reaches 2^COORD_BITS; keep the low port bits
  logic [COORD_BITS-1:0] sat_u, sat_v;
  logic [EXT_W-1:0]      ext_u, ext_v;
  res_t                  p_res;
  logic                  pv;

  always_comb begin
    sat_u = ch_qu[NSTEP][QW-1] ? '1 : ch_qu[NSTEP][QW-2:0];
    sat_v = ch_qv[NSTEP][QW-1] ? '1 : ch_qv[NSTEP][QW-2:0];
    ext_u = EXT_W'(sat_u);
    ext_v = EXT_W'(sat_v);
    p_res.face  = ch_side[NSTEP].face;
    p_res.degen = ch_side[NSTEP].degen;
    // zero vector: nothing to divide by, coordinates forced to zero
    p_res.cu    = ch_side[NSTEP].degen ? '0 : ext_u[COORD_W-1:0];
    p_res.cv    = ch_side[NSTEP].degen ? '0 : ext_v[COORD_W-1:0];
    pv          = v_r[NV-1];
  end

  // output register plus skid slot
  res_t o_r, o_nxt, sk_r, sk_nxt;

  always_comb begin
    o_nxt        = o_r;
    o_valid_nxt  = o_valid_r;
    sk_nxt       = sk_r;
    sk_valid_nxt = sk_valid_r;
    if (!o_valid_r || out_ready) begin
      if (sk_valid_r) begin
        o_nxt        = sk_r;
        o_valid_nxt  = 1'b1;
        sk_valid_nxt = 1'b0;
      end else begin
        o_nxt       = p_res;
        o_valid_nxt = pv;
      end
    end else if (pv && !sk_valid_r) begin
      // output stalled: park the item that just left the pipeline
      sk_nxt       = p_res;
      sk_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r  <= 1'b0;
      sk_valid_r <= 1'b0;
    end else begin
      o_valid_r  <= o_valid_nxt;
      sk_valid_r <= sk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_r  <= o_nxt;
    sk_r <= sk_nxt;
  end

  assign out_valid      = o_valid_r;
  assign out_face       = o_r.face;
  assign out_coord_u    = o_r.cu;
  assign out_coord_v    = o_r.cv;
  assign out_degenerate = o_r.degen;

  `CMFS_ASSERT_HOLDS(a_skid_behind_out, clk, rst_n, sk_valid_r, o_valid_r,
    "skid slot holds an item while the output register is empty")
  `CMFS_ASSERT_HOLDS(a_skid_fill_on_stall, clk, rst_n, $rose(sk_valid_r),
    $past(o_valid_r && !out_ready), "skid slot filled without an output stall")
  `CMFS_ASSERT_HOLDS(a_degen_zero, clk, rst_n, o_valid_r && o_r.degen,
    o_r.face == FACE_NZ && o_r.cu == '0 && o_r.cv == '0,
    "degenerate item with nonzero coordinates or wrong face")
  `CMFS_ASSERT_HOLDS(a_face_range, clk, rst_n, o_valid_r, o_r.face <= FACE_NZ,
    "face index out of range")

endmodule
